FILE: design/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// types, character constants and helpers shared by the json string escaper
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // how the string byte of an item expands
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,   // byte passes through
    KIND_SHORT = 2'd1,   // backslash and one character
    KIND_UNI   = 2'd2    // backslash u 0 0 hex hex
  } esc_kind_t;

  // one classified item waiting for the expander
  typedef struct packed {
    logic      open_q;   // opening quote first
    logic      has_char; // a string byte follows
    esc_kind_t kind;
    logic [7:0] data;    // raw byte, or the character after the backslash for short escapes
    logic      close_q;  // closing quote last
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

endpackage

`default_nettype wire

FILE: design/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// accepts input words, tracks the string start and classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [7:0]        in_tdata,
  input  wire               in_tuser,
  input  wire               in_tlast,
  input  wire               q_full,
  output logic              q_push,
  output jse_pkg::desc_t    q_desc,
  output logic              at_start
);
  import jse_pkg::*;

  logic at_start_r, at_start_nxt;
  logic accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  // a word with no byte and no end makes nothing
  assign q_push    = accept && (in_tuser || in_tlast);
  assign at_start  = at_start_r;

  always_comb begin
    q_desc.open_q   = at_start_r;
    q_desc.has_char = in_tuser;
    q_desc.close_q  = in_tlast;
    q_desc.kind     = KIND_SHORT;
    q_desc.data     = in_tdata;
    unique case (in_tdata)
      8'h22:   q_desc.data = 8'h22;
      8'h5C:   q_desc.data = 8'h5C;
      8'h0A:   q_desc.data = 8'h6E; // n
      8'h09:   q_desc.data = 8'h74; // t
      8'h0D:   q_desc.data = 8'h72; // r
      8'h08:   q_desc.data = 8'h62; // b
      8'h0C:   q_desc.data = 8'h66; // f
      default: begin
        q_desc.kind = (in_tdata < CTRL_LIMIT) ? KIND_UNI : KIND_PLAIN;
      end
    endcase
  end

  always_comb begin
    at_start_nxt = at_start_r;
    if (q_push) begin
      at_start_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else begin
      at_start_r <= at_start_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// short descriptor queue between the classifier and the expander
// ----------------------------------------------------------------------------
`default_nettype none

module jse_fifo #(
  parameter int QDEPTH = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  jse_pkg::desc_t    push_desc,
  input  wire               pop,
  output jse_pkg::desc_t    head,
  output logic              empty,
  output logic              full
);
  import jse_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  desc_t          slots_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: design/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// expands one descriptor into output words through a registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back (
  input  wire               clk,
  input  wire               rst_n,
  input  jse_pkg::desc_t    head,
  input  wire               q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import jse_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r, out_done_r;
  logic [2:0] idx_r, idx_nxt;

  logic       advance, load;
  logic [2:0] nchar, last_idx, j;
  logic [3:0] nbeats;
  logic [7:0] beat_data;
  logic       beat_done, beat_last;

  assign advance = !out_valid_r || out_tready;
  assign load    = advance && !q_empty;

  always_comb begin
    unique case (head.kind)
      KIND_PLAIN: nchar = 3'd1;
      KIND_SHORT: nchar = 3'd2;
      KIND_UNI:   nchar = 3'd6;
      default:    nchar = 3'd1;
    endcase
    if (!head.has_char) begin
      nchar = 3'd0;
    end
    nbeats    = {3'b000, head.open_q} + {1'b0, nchar} + {3'b000, head.close_q};
    last_idx  = 3'(nbeats - 4'd1);
    beat_last = (idx_r == last_idx);
    j         = idx_r - {2'b00, head.open_q};
  end

  always_comb begin
    beat_data = CH_QUOTE;
    beat_done = 1'b0;
    priority if (head.open_q && idx_r == 3'd0) begin
      beat_data = CH_QUOTE;
    end else if (head.has_char && j < nchar) begin
      unique case (head.kind)
        KIND_PLAIN: beat_data = head.data;
        KIND_SHORT: beat_data = (j == 3'd0) ? CH_BSLASH : head.data;
        KIND_UNI: begin
          unique case (j)
            3'd0:    beat_data = CH_BSLASH;
            3'd1:    beat_data = CH_U;
            3'd2:    beat_data = CH_ZERO;
            3'd3:    beat_data = CH_ZERO;
            3'd4:    beat_data = hex_char(head.data[7:4]);
            default: beat_data = hex_char(head.data[3:0]);
          endcase
        end
        default:    beat_data = head.data;
      endcase
    end else begin
      beat_data = CH_QUOTE;
      beat_done = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;
    if (advance) begin
      out_valid_nxt = !q_empty;
    end
    if (load) begin
      if (beat_last) begin
        idx_nxt = 3'd0;
        q_pop   = 1'b1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= beat_data;
      out_last_r <= beat_last;
      out_done_r <= beat_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire

FILE: design/json_string_escaper_top.sv
// path: an accepted input word is stored in the descriptor queue, then its first output word is registered
// throughput: one input word per cycle while each expands to one output word
//   and out_tready is high; a word expands to up to 8 output words (quotes,
//   escapes), one per cycle, so the single-beat expander paces the stream
// reset: rst_n synchronous active low; empties the queue and output stage
//   and arms the opening quote
// ----------------------------------------------------------------------------
// json_string_escaper_top
// streams string bytes in and gives the quoted, escaped json text out
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_top #(
  parameter int QDEPTH = 4        // descriptor queue depth, at least 2
) (
  input  wire        clk,
  input  wire        rst_n,
  // input stream
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,    // [7:0] char_byte
  input  wire        in_tlast,    // string_end
  input  wire        in_tuser,    // [0] carries_char
  // output stream
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,   // run_last
  output logic       out_tuser    // [0] string_done
);
  import jse_pkg::*;

  desc_t push_desc, head;
  logic  q_push, q_pop, q_empty, q_full;
  logic  at_start;

  // front: accept a word, classify its byte, track the pending opening quote
  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc),
    .at_start  (at_start)
  );

  // queue lets the front keep taking words while the back stalls on escapes
  jse_fifo #(
    .QDEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: one output word per cycle unless out_tready stalls it, pops the descriptor on its last word
  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // closing quote is always the last word of its run
  a_done_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == CH_QUOTE))
    else $error("string_done word is not a final closing quote");

  // an accepted end word re-arms the opening quote
  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> at_start)
    else $error("opening quote not re-armed after string end");

  // a byte-carrying word without end clears the pending quote
  a_char_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && !in_tlast) |=> !at_start)
    else $error("opening quote still pending after a string byte");

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
